### hdl/bss_pkg.sv
// shared constants and types for the bounded stack with search and sort
package bss_pkg;

  localparam int DEPTH = 64;
  localparam int IDXW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int WORDW = 32;
  localparam int CAPW = 7;
  localparam int CMDW = 2;
  localparam int STW = 3;

  localparam int POP_LSB = 0;
  localparam int FIDX_LSB = POP_LSB + WORDW;
  localparam int TOT_LSB = FIDX_LSB + IDXW;
  localparam int OUT_USED = TOT_LSB + CNTW;
  localparam int OUT_DATAW = ((OUT_USED + 7) / 8) * 8;

  typedef enum logic [CMDW-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_SORT   = 2'd3
  } cmd_e;

  typedef enum logic [STW-1:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FOUND    = 3'd4
  } status_e;

endpackage

### hdl/bounded_stack_search_sort.sv
// bounded stack of signed words with search and in-place bubble sort
//
// requests enter on the s_axis group: tuser carries the command (push, pop,
// search, sort), tdata the operand word. one result leaves on the m_axis
// group per request: tuser carries the status, tdata the popped word, the
// found index and the entry count after the operation.
// cfg_we_i writes the capacity register (clamped to DEPTH when used); the user
// must write it only while no request is in progress; the block does not enforce it.
// search reads the entries from index 0 upward and stops at the first
// match; sort runs bubble passes, each over one fewer entry. all work runs
// through one memory read port, one write port, one sort comparator and one
// search comparator under the sequencer, so a single request is in flight.
// s_axis_tready is high when the sequencer is idle and the result register
// is empty or being taken; a stalled receiver holds the result and blocks
// the next request. reset empties the stack and sets the capacity to 64;
// the word store itself is not cleared.
module bounded_stack_search_sort
  import bss_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CAPW-1:0]      cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [WORDW-1:0]     s_axis_tdata,   // operand_value
  input  logic [CMDW-1:0]      s_axis_tuser,   // cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_DATAW-1:0] m_axis_tdata,   // popped_value, found_index, entry_total
  output logic [STW-1:0]       m_axis_tuser    // status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SRCH,
    S_SORT_FIRST,
    S_SORT_STEP,
    S_SORT_END
  } state_e;

  logic [WORDW-1:0] stack_mem [DEPTH];

  state_e           state_q, state_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic [CAPW-1:0]  cap_q;
  logic [WORDW-1:0] opnd_q, opnd_d;
  logic [IDXW-1:0]  idx_q, idx_d;
  logic [IDXW-1:0]  last_q, last_d;
  logic [WORDW-1:0] cur_q, cur_d;
  logic [WORDW-1:0] rd_q;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [WORDW-1:0] out_popped_q, out_popped_d;
  logic [IDXW-1:0]  out_fidx_q, out_fidx_d;
  logic [CNTW-1:0]  out_total_q, out_total_d;

  logic             mem_we;
  logic [IDXW-1:0]  mem_waddr;
  logic [WORDW-1:0] mem_wdata;
  logic [IDXW-1:0]  rd_addr;

  logic             accept;
  logic [CNTW-1:0]  usable;
  logic [CNTW-1:0]  count_m1;
  logic             swap;
  cmd_e             cmd;

  assign cmd = cmd_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign usable = (cap_q > CAPW'(DEPTH)) ? CNTW'(DEPTH) : CNTW'(cap_q);
  assign count_m1 = count_q - CNTW'(1);
  assign swap = $signed(cur_q) > $signed(rd_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    opnd_d = opnd_q;
    idx_d = idx_q;
    last_d = last_q;
    cur_d = cur_q;
    mem_we = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = cur_q;
    rd_addr = '0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_popped_d = out_popped_q;
    out_fidx_d = out_fidx_q;
    out_total_d = out_total_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_popped_d = '0;
          out_fidx_d = '0;
          out_total_d = count_q;
          unique case (cmd)
            CMD_PUSH: begin
              out_valid_d = 1'b1;
              if (count_q >= usable) begin
                out_status_d = ST_OVERFLOW;
              end else begin
                mem_we = 1'b1;
                mem_waddr = count_q[IDXW-1:0];
                mem_wdata = s_axis_tdata;
                count_d = count_q + CNTW'(1);
                out_status_d = ST_OK;
                out_total_d = count_q + CNTW'(1);
              end
            end
            CMD_POP: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                out_status_d = ST_UNDERFLOW;
              end else begin
                rd_addr = count_m1[IDXW-1:0];
                count_d = count_m1;
                state_d = S_POP;
              end
            end
            CMD_SEARCH: begin
              opnd_d = s_axis_tdata;
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                out_status_d = ST_NOTFOUND;
              end else begin
                idx_d = '0;
                state_d = S_SRCH;
              end
            end
            CMD_SORT: begin
              if (count_q <= CNTW'(1)) begin
                out_valid_d = 1'b1;
                out_status_d = ST_OK;
              end else begin
                last_d = count_m1[IDXW-1:0];
                state_d = S_SORT_FIRST;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        out_valid_d = 1'b1;
        out_status_d = ST_OK;
        out_popped_d = rd_q;
        out_total_d = count_q;
        state_d = S_IDLE;
      end
      S_SRCH: begin
        if (rd_q == opnd_q) begin
          out_valid_d = 1'b1;
          out_status_d = ST_FOUND;
          out_fidx_d = idx_q;
          state_d = S_IDLE;
        end else if ({1'b0, idx_q} == count_m1) begin
          out_valid_d = 1'b1;
          out_status_d = ST_NOTFOUND;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IDXW'(1);
          rd_addr = idx_q + IDXW'(1);
        end
      end
      S_SORT_FIRST: begin
        cur_d = rd_q;
        idx_d = IDXW'(1);
        rd_addr = IDXW'(1);
        state_d = S_SORT_STEP;
      end
      S_SORT_STEP: begin
        mem_we = 1'b1;
        mem_waddr = idx_q - IDXW'(1);
        mem_wdata = swap ? rd_q : cur_q;
        cur_d = swap ? cur_q : rd_q;
        if (idx_q == last_q) begin
          state_d = S_SORT_END;
        end else begin
          idx_d = idx_q + IDXW'(1);
          rd_addr = idx_q + IDXW'(1);
        end
      end
      S_SORT_END: begin
        mem_we = 1'b1;
        mem_waddr = last_q;
        mem_wdata = cur_q;
        if (last_q == IDXW'(1)) begin
          out_valid_d = 1'b1;
          out_status_d = ST_OK;
          state_d = S_IDLE;
        end else begin
          last_d = last_q - IDXW'(1);
          state_d = S_SORT_FIRST;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // word store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      cap_q <= CAPW'(64);
      opnd_q <= '0;
      idx_q <= '0;
      last_q <= '0;
      cur_q <= '0;
      out_valid_q <= 1'b0;
      out_status_q <= ST_OK;
      out_popped_q <= '0;
      out_fidx_q <= '0;
      out_total_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      opnd_q <= opnd_d;
      idx_q <= idx_d;
      last_q <= last_d;
      cur_q <= cur_d;
      out_valid_q <= out_valid_d;
      out_status_q <= out_status_d;
      out_popped_q <= out_popped_d;
      out_fidx_q <= out_fidx_d;
      out_total_q <= out_total_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = out_status_q;
  assign m_axis_tdata = OUT_DATAW'({out_total_q, out_fidx_q, out_popped_q});

endmodule

### hdl/bss_checker.sv
// port-level checks for the bounded stack, bound to the top level
module bss_checker
  import bss_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [CMDW-1:0]      s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OUT_DATAW-1:0] m_axis_tdata,
  input logic [STW-1:0]       m_axis_tuser
);

  logic [IDXW-1:0] fidx;
  logic [CNTW-1:0] total;

  assign fidx = m_axis_tdata[FIDX_LSB +: IDXW];
  assign total = m_axis_tdata[TOT_LSB +: CNTW];

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_push_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_PUSH) |=> m_axis_tvalid)
    else $error("push result not presented on the next cycle");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_UNDERFLOW) |-> (total == '0))
    else $error("underflow reported with entries held");

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FOUND) |-> ({1'b0, fidx} < total))
    else $error("found index beyond entry count");

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (total <= CNTW'(DEPTH)))
    else $error("entry count above depth");

endmodule

bind bounded_stack_search_sort bss_checker u_bss_checker (.*);

### tb/bounded_stack_search_sort_tb.sv
// testbench for the bounded stack: directed corner cases and random stream traffic checked against a stack predictor
module bounded_stack_search_sort_tb
  import bss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime CLK_PERIOD = 12.0;
  localparam longint unsigned WATCHDOG_CYCLES = 8_000_000;
  localparam int RESET_CYCLES = 7;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 102;
  localparam int HOLD_AT = 150;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    status_e          st;
    logic [WORDW-1:0] popped;
    logic [IDXW-1:0]  fidx;
    logic [CNTW-1:0]  total;
  } stack_result_t;

  class stack_tracker;
    logic [WORDW-1:0] words [DEPTH];
    int unsigned      held;
    int unsigned      cap;
    stack_result_t    awaited [$];
    int unsigned      errors;

    function new();
      held = 0;
      cap = DEPTH;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAPW-1:0] v);
      cap = v;
    endfunction

    function int unsigned usable();
      return (cap > DEPTH) ? DEPTH : cap;
    endfunction

    function void note_request(cmd_e c, logic [WORDW-1:0] v);
      stack_result_t r;
      logic [WORDW-1:0] t;
      r.st = ST_OK;
      r.popped = '0;
      r.fidx = '0;
      case (c)
        CMD_PUSH: begin
          if (held >= usable()) r.st = ST_OVERFLOW;
          else begin
            words[held] = v;
            held++;
          end
        end
        CMD_POP: begin
          if (held == 0) r.st = ST_UNDERFLOW;
          else begin
            held--;
            r.popped = words[held];
          end
        end
        CMD_SEARCH: begin
          r.st = ST_NOTFOUND;
          for (int i = 0; i < held; i++) begin
            if (words[i] == v) begin
              r.st = ST_FOUND;
              r.fidx = IDXW'(i);
              break;
            end
          end
        end
        default: begin
          for (int i = 0; i + 1 < held; i++) begin
            for (int j = 0; j + 1 < held - i; j++) begin
              if ($signed(words[j]) > $signed(words[j+1])) begin
                t = words[j];
                words[j] = words[j+1];
                words[j+1] = t;
              end
            end
          end
        end
      endcase
      r.total = CNTW'(held);
      awaited.push_back(r);
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [STW-1:0] st, logic [OUT_DATAW-1:0] d);
      stack_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d data %h",
                 $time, st, d);
        errors++;
        return;
      end
      e = awaited.pop_front();
      compare("status", e.st, st);
      compare("popped_value", e.popped, d[POP_LSB +: WORDW]);
      compare("found_index", e.fidx, d[FIDX_LSB +: IDXW]);
      compare("entry_total", e.total, d[TOT_LSB +: CNTW]);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CAPW-1:0]      cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [WORDW-1:0]     s_axis_tdata = '0;
  logic [CMDW-1:0]      s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_DATAW-1:0] m_axis_tdata;
  logic [STW-1:0]       m_axis_tuser;

  stack_tracker tracker = new();
  bit           no_gaps = 1'b0;
  logic [CAPW-1:0] phase_caps [PHASES];

  bounded_stack_search_sort dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 10);
  endfunction

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      tracker.note_request(cmd_e'(s_axis_tuser), s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready)
      tracker.check_result(m_axis_tuser, m_axis_tdata);
  end

  // result side, with one long hold-off so the block backs up
  initial begin
    int gap;
    int unsigned taken;
    bit long_done;
    taken = 0;
    long_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!long_done && taken == HOLD_AT) begin
        gap = LONG_HOLD;
        long_done = 1'b1;
      end else begin
        gap = draw_gap();
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
      @(negedge clk_i);
    end
  end

  task automatic send_request(cmd_e c, logic [WORDW-1:0] v);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    s_axis_tuser <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CAPW-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_capacity(v);
  endtask

  initial begin
    #(CLK_PERIOD * WATCHDOG_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    cmd_e c;
    logic [WORDW-1:0] v;
    int r;
    bit filling;
    phase_caps = '{7'd127, 7'd1, 7'd64, 7'd0, 7'd5, 7'd100, 7'd2, 7'd64, 7'd33, 7'd127};
    filling = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty stack corner cases
    send_request(CMD_POP, 32'h0);
    send_request(CMD_SEARCH, 32'h0);
    send_request(CMD_SORT, 32'h0);
    // extremes, duplicates and signed ordering
    send_request(CMD_PUSH, 32'h7fff_ffff);
    send_request(CMD_PUSH, 32'h8000_0000);
    send_request(CMD_PUSH, 32'h0000_0000);
    send_request(CMD_PUSH, 32'hffff_ffff);
    send_request(CMD_PUSH, 32'h0000_0001);
    send_request(CMD_PUSH, 32'h7fff_ffff);
    send_request(CMD_SEARCH, 32'h7fff_ffff);
    send_request(CMD_SEARCH, 32'h8000_0000);
    send_request(CMD_SEARCH, 32'h0000_3039);
    send_request(CMD_SORT, 32'hdead_beef);
    send_request(CMD_SEARCH, 32'h7fff_ffff);
    send_request(CMD_POP, 32'h0);
    send_request(CMD_POP, 32'h0);
    // capacity lowered below the count
    write_capacity(7'd2);
    send_request(CMD_PUSH, 32'h1234_5678);
    send_request(CMD_POP, 32'h0);
    send_request(CMD_POP, 32'h0);
    send_request(CMD_PUSH, 32'h1234_5678);
    send_request(CMD_POP, 32'h0);
    send_request(CMD_PUSH, 32'haaaa_aaaa);
    send_request(CMD_SORT, 32'h0);
    // capacity zero
    write_capacity(7'd0);
    send_request(CMD_PUSH, 32'h5555_5555);
    send_request(CMD_POP, 32'h0);
    send_request(CMD_POP, 32'h0);
    send_request(CMD_POP, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      no_gaps = (p % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (filling && tracker.held >= tracker.usable() && $urandom_range(0, 3) == 0)
          filling = 1'b0;
        else if (!filling && tracker.held == 0 && $urandom_range(0, 3) == 0)
          filling = 1'b1;
        else if ($urandom_range(0, 49) == 0)
          filling = ~filling;
        r = $urandom_range(0, 99);
        if (r < 4) c = CMD_SORT;
        else if (r < 18) c = CMD_SEARCH;
        else if (r < (filling ? 88 : 30)) c = CMD_PUSH;
        else c = CMD_POP;
        case ($urandom_range(0, 9))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2, 3, 4: v = WORDW'($signed($urandom_range(0, 8)) - 4);
          default: v = $urandom();
        endcase
        if (c == CMD_SEARCH && tracker.held > 0 && $urandom_range(0, 2) != 0)
          v = tracker.words[$urandom_range(0, tracker.held - 1)];
        send_request(c, v);
      end
    end

    s_axis_tvalid <= 1'b0;
    no_gaps = 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (tracker.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
hdl/bss_pkg.sv
hdl/bounded_stack_search_sort.sv
hdl/bss_checker.sv
tb/bounded_stack_search_sort_tb.sv
